### design/acd_pkg.sv
// acd_pkg: types, field widths, register indexes and reset constants
// for the adaptive cull distance block
// no dependencies; compiled first
package acd_pkg;

    // fixed field widths
    localparam int POS_W      = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = SQ_W + 2;
    localparam int LEVEL_W    = 40;
    localparam int TARGET_W   = 10;
    localparam int MAXC_W     = 34;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 34;

    // near test: 10*dist + 10 <= 11*t, that is dist + 1 <= t + t/10 with exact t/10
    localparam int NEAR_SCALE       = 10;
    localparam int NEAR_LIMIT_SCALE = 11;

    // commands
    localparam logic CMD_OBJECT    = 1'b0;
    localparam logic CMD_FRAME_END = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DRAWN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CULL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAWN_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_GAIN  = 2'd3;

    // reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET      = 10'd50;
    localparam logic [MAXC_W-1:0]   MAX_CULL_RESET    = 34'd100000000;
    localparam logic [GAIN_W-1:0]   DRAWN_GAIN_RESET  = 16'd33333;
    localparam logic [GAIN_W-1:0]   SPREAD_GAIN_RESET = 16'd50000;
    localparam logic [63:0]         CULL_RESET        = 64'd100000000;

    typedef struct packed {
        logic                    cmd;
        logic signed [POS_W-1:0] obj_x;
        logic signed [POS_W-1:0] obj_y;
        logic signed [POS_W-1:0] obj_z;
        logic signed [POS_W-1:0] ref_x;
        logic signed [POS_W-1:0] ref_y;
        logic signed [POS_W-1:0] ref_z;
        logic                    ref_present;
        logic                    time_stopped;
    } item_t;

    // distance compare outcome
    typedef struct packed {
        logic hit;
        logic near;
    } cmp_t;

endpackage

### design/acd_if.sv
// acd_item_if and acd_result_if: valid/ready channels of the cull block
// depend on acd_pkg for field widths
interface acd_item_if;
    import acd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [POS_W-1:0] obj_x;
    logic signed [POS_W-1:0] obj_y;
    logic signed [POS_W-1:0] obj_z;
    logic signed [POS_W-1:0] ref_x;
    logic signed [POS_W-1:0] ref_y;
    logic signed [POS_W-1:0] ref_z;
    logic                    ref_present;
    logic                    time_stopped;

    modport source (
        output valid, cmd, obj_x, obj_y, obj_z, ref_x, ref_y, ref_z,
               ref_present, time_stopped,
        input  ready
    );
    modport sink (
        input  valid, cmd, obj_x, obj_y, obj_z, ref_x, ref_y, ref_z,
               ref_present, time_stopped,
        output ready
    );
endinterface

interface acd_result_if;
    import acd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      animate;
    logic signed [LEVEL_W-1:0] cull_level;

    modport source (
        output valid, animate, cull_level,
        input  ready
    );
    modport sink (
        input  valid, animate, cull_level,
        output ready
    );
endinterface

### design/adaptive_cull_distance.sv
// an accepted item is held in the stage register and then moves to the result register
// throughput: one item per cycle while results.ready holds; the stage register and the result register
//   advance together, and while a result waits the stage holds at most one item
// all work for an item sits between the stage register and the result register
// reset: threshold 100000000, counts zero, registers at their reset values
module adaptive_cull_distance
    import acd_pkg::*;
#(
    parameter int COUNT_BITS = 10,
    parameter int CULL_BITS  = 40
) (
    input  logic                  clk,
    input  logic                  rst_n,
    acd_item_if.sink              items,
    acd_result_if.source          results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [TARGET_W-1:0] target_drawn_reg;
    logic [MAXC_W-1:0]   max_cull_reg;
    logic [GAIN_W-1:0]   drawn_gain_reg;
    logic [GAIN_W-1:0]   spread_gain_reg;

    // adaptive state
    logic signed [CULL_BITS-1:0] thr_reg, thr_next;
    logic [COUNT_BITS-1:0]       drawn_count_reg, drawn_count_next;
    logic [COUNT_BITS-1:0]       near_count_reg, near_count_next;

    // stage register between the input channel and the compute logic
    item_t stage_reg;
    logic  stage_valid_reg;

    // result register
    logic                      res_valid_reg;
    logic                      res_animate_reg, res_animate_next;
    logic signed [LEVEL_W-1:0] res_level_reg, res_level_next;

    logic                        advance;
    logic                        is_frame, frame_upd, obj_check;
    cmp_t                        cmp;
    logic signed [CULL_BITS-1:0] upd_thr;
    logic signed [63:0]          level_wide;

    // the stage moves into the result register when that slot is free or being emptied
    assign advance     = stage_valid_reg && (!res_valid_reg || results.ready);
    assign items.ready = !stage_valid_reg || advance;

    assign results.valid      = res_valid_reg;
    assign results.animate    = res_animate_reg;
    assign results.cull_level = res_level_reg;

    acd_dist #(
        .CULL_BITS (CULL_BITS)
    ) u_dist (
        .item      (stage_reg),
        .threshold (thr_reg),
        .cmp       (cmp)
    );

    acd_update #(
        .COUNT_BITS (COUNT_BITS),
        .CULL_BITS  (CULL_BITS)
    ) u_update (
        .threshold      (thr_reg),
        .drawn_count    (drawn_count_reg),
        .near_count     (near_count_reg),
        .target_drawn   (target_drawn_reg),
        .max_cull       (max_cull_reg),
        .drawn_gain     (drawn_gain_reg),
        .spread_gain    (spread_gain_reg),
        .threshold_next (upd_thr)
    );

    // item decode and next state
    always_comb
    begin
        is_frame  = (stage_reg.cmd == CMD_FRAME_END);
        frame_upd = is_frame && !stage_reg.time_stopped;
        obj_check = !is_frame && stage_reg.ref_present;

        // object with no reference: always animated, nothing counted
        res_animate_next = !is_frame && (!stage_reg.ref_present || cmp.hit);

        thr_next         = frame_upd ? upd_thr : thr_reg;
        drawn_count_next = drawn_count_reg;
        near_count_next  = near_count_reg;
        if (frame_upd)
        begin
            drawn_count_next = '0;
            near_count_next  = '0;
        end
        else if (obj_check)
        begin
            // counts saturate when full
            if (cmp.hit && (drawn_count_reg != '1))
                drawn_count_next = drawn_count_reg + 1'b1;
            if (cmp.near && (near_count_reg != '1))
                near_count_next = near_count_reg + 1'b1;
        end

        // level is the threshold seen as 40 bits
        level_wide     = 64'(thr_next);
        res_level_next = level_wide[LEVEL_W-1:0];
    end

    // control, configuration and adaptive state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            res_valid_reg    <= 1'b0;
            target_drawn_reg <= TARGET_RESET;
            max_cull_reg     <= MAX_CULL_RESET;
            drawn_gain_reg   <= DRAWN_GAIN_RESET;
            spread_gain_reg  <= SPREAD_GAIN_RESET;
            thr_reg          <= $signed(CULL_BITS'(CULL_RESET));
            drawn_count_reg  <= '0;
            near_count_reg   <= '0;
        end
        else
        begin
            if (items.ready)
                stage_valid_reg <= items.valid;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (results.ready)
                res_valid_reg <= 1'b0;

            if (advance)
            begin
                thr_reg         <= thr_next;
                drawn_count_reg <= drawn_count_next;
                near_count_reg  <= near_count_next;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TARGET_DRAWN: target_drawn_reg <= cfg_data[TARGET_W-1:0];
                    CFG_MAX_CULL:     max_cull_reg     <= cfg_data[MAXC_W-1:0];
                    CFG_DRAWN_GAIN:   drawn_gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_SPREAD_GAIN:  spread_gain_reg  <= cfg_data[GAIN_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            stage_reg.cmd          <= items.cmd;
            stage_reg.obj_x        <= items.obj_x;
            stage_reg.obj_y        <= items.obj_y;
            stage_reg.obj_z        <= items.obj_z;
            stage_reg.ref_x        <= items.ref_x;
            stage_reg.ref_y        <= items.ref_y;
            stage_reg.ref_z        <= items.ref_z;
            stage_reg.ref_present  <= items.ref_present;
            stage_reg.time_stopped <= items.time_stopped;
        end
        if (advance)
        begin
            res_animate_reg <= res_animate_next;
            res_level_reg   <= res_level_next;
        end
    end

    // a frame-end update leaves both counts cleared
    a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_upd |=> (drawn_count_reg == '0) && (near_count_reg == '0))
        else $error("counts not cleared after frame-end update");

    // after a frame-end update the threshold is at or below max_cull
    a_thr_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_upd |=>
            (thr_reg[CULL_BITS-1] || (thr_reg <= CULL_BITS'(max_cull_reg))))
        else $error("threshold above max_cull after update");

    // the threshold only moves on a frame-end update
    a_thr_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && frame_upd) |=> $stable(thr_reg))
        else $error("threshold changed outside a frame-end update");

    // between updates the drawn count never falls
    a_drawn_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && frame_upd) |=> (drawn_count_reg >= $past(drawn_count_reg)))
        else $error("drawn count fell between frame-end updates");

    // a frame-end transaction never reports an animated object
    a_frame_not_animated: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_frame |=> !res_animate_reg)
        else $error("frame-end result marked animated");

endmodule

### design/acd_dist.sv
// acd_dist: squared distance of an object from the reference and its
// compare against the cull threshold and the near limit; uses acd_pkg
module acd_dist
    import acd_pkg::*;
#(
    parameter int CULL_BITS = 40
) (
    input  item_t                       item,
    input  logic signed [CULL_BITS-1:0] threshold,
    output cmp_t                        cmp
);

    localparam int CMP_W = ((DIST_W > CULL_BITS) ? DIST_W : CULL_BITS) + 4;

    logic signed [DIFF_W-1:0]   dx, dy, dz;
    logic signed [2*DIFF_W-1:0] px, py, pz;
    logic [DIST_W-1:0]          dist_sq;
    logic [CMP_W-1:0]           dist_w, thr_w, lhs, rhs;
    logic                       thr_neg;

    always_comb
    begin
        dx = {item.obj_x[POS_W-1], item.obj_x} - {item.ref_x[POS_W-1], item.ref_x};
        dy = {item.obj_y[POS_W-1], item.obj_y} - {item.ref_y[POS_W-1], item.ref_y};
        dz = {item.obj_z[POS_W-1], item.obj_z} - {item.ref_z[POS_W-1], item.ref_z};
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
        // each square stays below 2^32
        dist_sq = DIST_W'(px[SQ_W-1:0]) + DIST_W'(py[SQ_W-1:0]) + DIST_W'(pz[SQ_W-1:0]);

        thr_neg = threshold[CULL_BITS-1];
        dist_w  = CMP_W'(dist_sq);
        thr_w   = CMP_W'(threshold[CULL_BITS-2:0]);
        // t/10 taken exactly by scaling both sides of the compare by 10
        lhs = dist_w * CMP_W'(NEAR_SCALE) + CMP_W'(NEAR_SCALE);
        rhs = thr_w * CMP_W'(NEAR_LIMIT_SCALE);

        cmp.hit  = !thr_neg && (dist_w <= thr_w);
        cmp.near = !thr_neg && (lhs <= rhs);
    end

endmodule

### design/acd_update.sv
// acd_update: frame-end threshold correction from drawn and near counts,
// clamped at max_cull and saturated at the signed low bound; uses acd_pkg
module acd_update
    import acd_pkg::*;
#(
    parameter int COUNT_BITS = 10,
    parameter int CULL_BITS  = 40
) (
    input  logic signed [CULL_BITS-1:0] threshold,
    input  logic [COUNT_BITS-1:0]       drawn_count,
    input  logic [COUNT_BITS-1:0]       near_count,
    input  logic [TARGET_W-1:0]         target_drawn,
    input  logic [MAXC_W-1:0]           max_cull,
    input  logic [GAIN_W-1:0]           drawn_gain,
    input  logic [GAIN_W-1:0]           spread_gain,
    output logic signed [CULL_BITS-1:0] threshold_next
);

    localparam int CNT_W   = (COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W;
    localparam int ERR_W   = CNT_W + 1;
    localparam int PROD_W  = GAIN_W + 1 + ERR_W;
    localparam int DELTA_W = PROD_W + 1;
    localparam int SUM_W   = ((DELTA_W > CULL_BITS) ? DELTA_W : CULL_BITS) + 1;

    logic signed [ERR_W-1:0]     err_drawn, err_spread;
    logic signed [GAIN_W:0]      dg_s, sg_s;
    logic signed [PROD_W-1:0]    prod_drawn, prod_spread;
    logic signed [DELTA_W-1:0]   delta;
    logic signed [SUM_W-1:0]     diff, lo_w, mc_w;
    logic signed [CULL_BITS-1:0] low_bound;

    always_comb
    begin
        err_drawn  = $signed({1'b0, CNT_W'(drawn_count)}) - $signed({1'b0, CNT_W'(target_drawn)});
        err_spread = $signed({1'b0, CNT_W'(near_count)}) - $signed({1'b0, CNT_W'(drawn_count)});
        dg_s       = $signed({1'b0, drawn_gain});
        sg_s       = $signed({1'b0, spread_gain});

        prod_drawn  = PROD_W'(dg_s) * PROD_W'(err_drawn);
        prod_spread = PROD_W'(sg_s) * PROD_W'(err_spread);
        delta       = DELTA_W'(prod_drawn) + DELTA_W'(prod_spread);

        low_bound = {1'b1, {(CULL_BITS-1){1'b0}}};
        lo_w      = SUM_W'(low_bound);
        mc_w      = $signed({{(SUM_W-MAXC_W){1'b0}}, max_cull});
        diff      = SUM_W'(threshold) - SUM_W'(delta);

        priority if (diff < lo_w)
            threshold_next = low_bound;
        else if (diff > mc_w)
            threshold_next = $signed(CULL_BITS'(max_cull));
        else
            threshold_next = diff[CULL_BITS-1:0];
    end

endmodule
